// ===== sv/timestamped_mixing_ring_buffer_core_macros.svh =====
// Assertion macros used by the checker of the mixing ring buffer.
`ifndef TIMESTAMPED_MIXING_RING_BUFFER_CORE_MACROS_SVH
`define TIMESTAMPED_MIXING_RING_BUFFER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tmrb_pkg.sv =====
package tmrb_pkg;

    // Store geometry. The depth is a power of two, so index arithmetic wraps by truncation.
    localparam int STORE_FRAMES = 4096;
    localparam int LEAD_FRAMES  = 882;
    localparam int IDX_W        = $clog2(STORE_FRAMES);

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 12;
    localparam int CMD_W    = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_MIX_AT_TIME  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MIX_CONTINUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MIX_AT_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PLAY_TICK    = 2'd3;

    typedef logic [IDX_W-1:0] t_index;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // One stereo frame as held in the store: left in the low half, right in the high half.
    typedef struct packed {
        t_sample right;
        t_sample left;
    } t_frame;

    // Write port of the frame store.
    typedef struct packed {
        logic   en;
        t_index addr;
        t_frame data;
    } t_store_wr;

endpackage

// ===== sv/tmrb_store.sv =====
module tmrb_store (
    input  logic               i_clk,
    input  tmrb_pkg::t_store_wr i_wr,
    input  tmrb_pkg::t_index   i_rd_addr,
    output tmrb_pkg::t_frame   o_rd_data
);
    import tmrb_pkg::*;

    t_frame r_mem [STORE_FRAMES];
    t_frame r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/tmrb_mix_unit.sv =====
module tmrb_mix_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tmrb_pkg::t_frame i_stored,
    input  tmrb_pkg::t_frame i_new,
    output logic             o_done,
    output tmrb_pkg::t_frame o_mixed
);
    import tmrb_pkg::*;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_PREP = 3'd1;
    localparam logic [2:0] M_MUL  = 3'd2;
    localparam logic [2:0] M_DIV  = 3'd3;
    localparam logic [2:0] M_FIN  = 3'd4;

    localparam int          DIV_STEPS = 3;
    localparam logic [16:0] UNITY     = 17'h7fff;
    localparam logic [31:0] DIVISOR   = 32'h7fff;
    localparam logic [19:0] OFFSET2   = 20'hfffe;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic        r_chan;
    logic [1:0]  r_step;
    logic        r_done;
    t_frame      r_stored;
    t_frame      r_new;
    t_frame      r_mixed;
    logic [16:0] r_u;
    logic [16:0] r_v;
    logic [31:0] r_rem;
    logic [16:0] r_quo;

    t_sample            w_a;
    t_sample            w_b;
    t_sample            w_ha;
    t_sample            w_hb;
    logic [16:0]        w_q;
    logic [19:0]        w_sum2;
    logic signed [19:0] w_m;
    logic signed [19:0] w_r;
    t_sample            w_sat;
    t_sample            w_res;

    // Halve a sample, truncating toward zero.
    function automatic t_sample half_toward_zero(input t_sample s);
        t_sample sh;
        logic    fix;
        sh  = s >>> 1;
        fix = s[SAMPLE_W-1] & s[0];
        return t_sample'(sh + t_sample'(fix));
    endfunction

    // The channel currently being worked on.
    assign w_a  = r_chan ? r_stored.right : r_stored.left;
    assign w_b  = r_chan ? r_new.right    : r_new.left;
    assign w_ha = half_toward_zero(w_a);
    assign w_hb = half_toward_zero(w_b);

    // Final step of the mix formula with saturation; a zero sample passes the other one through.
    always_comb begin
        w_q    = r_quo + ((r_rem == DIVISOR) ? 17'd1 : 17'd0);
        w_sum2 = 20'({r_u, 1'b0}) + 20'({r_v, 1'b0});
        if ((r_u < UNITY) && (r_v < UNITY)) begin
            w_m = 20'(w_q);
        end else begin
            w_m = w_sum2 - 20'(w_q) - OFFSET2;
        end
        w_r = w_m - 20'sd32767;
        if (w_r > 20'sd32767) begin
            w_sat = 16'sh7fff;
        end else if (w_r < -20'sd32768) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_r[SAMPLE_W-1:0];
        end
        if (w_a == '0) begin
            w_res = w_b;
        end else if (w_b == '0) begin
            w_res = w_a;
        end else begin
            w_res = w_sat;
        end
    end

    // Sequencer: each channel runs prepare, multiply, three divide steps and finish.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: if (i_start) n_state = M_PREP;
            M_PREP: n_state = M_MUL;
            M_MUL:  n_state = M_DIV;
            M_DIV:  if (r_step == 2'(DIV_STEPS - 1)) n_state = M_FIN;
            M_FIN:  n_state = r_chan ? M_IDLE : M_PREP;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_FIN) && r_chan;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_stored <= i_stored;
                    r_new    <= i_new;
                    r_chan   <= 1'b0;
                end
            end
            M_PREP: begin
                r_u    <= 17'(UNITY + {w_ha[SAMPLE_W-1], w_ha});
                r_v    <= 17'(UNITY + {w_hb[SAMPLE_W-1], w_hb});
                r_step <= '0;
            end
            M_MUL: begin
                r_rem <= 32'(r_u * r_v);
                r_quo <= '0;
            end
            M_DIV: begin
                // Division by 2^15-1: fold the high part back onto the low part.
                r_quo  <= 17'(r_quo + 17'(r_rem >> 15));
                r_rem  <= 32'({17'd0, r_rem[14:0]} + (r_rem >> 15));
                r_step <= 2'(r_step + 2'd1);
            end
            M_FIN: begin
                if (r_chan) begin
                    r_mixed.right <= w_res;
                end else begin
                    r_mixed.left <= w_res;
                end
                r_chan <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_mixed = r_mixed;

endmodule

// ===== sv/timestamped_mixing_ring_buffer_core.sv =====
// Stereo frame ring of 4096 entries with timestamped mixing. After reset the block
// first clears the whole store, one entry per cycle, before it accepts its first
// transaction. A play tick reads the entry at the play index, takes the registered
// read data, and then clears the entry and hands over the frame once the output
// register is free. A mix transaction runs the store read, then prepare, multiply,
// three divide steps and finish per channel in the shared mix unit (one 17x17
// multiplier and a three-step divide by 32767 that serve left and right in turn),
// then the write back. One transaction is in work at a time; a finished result waits
// in the output register while the next transaction is taken.
module timestamped_mixing_ring_buffer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tmrb_pkg::CMD_W-1:0]          i_cmd,
    input  logic [tmrb_pkg::TIME_W-1:0]         i_frame_time,
    input  logic signed [tmrb_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [tmrb_pkg::SAMPLE_W-1:0] i_right_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tmrb_pkg::SAMPLE_W-1:0] o_out_left,
    output logic signed [tmrb_pkg::SAMPLE_W-1:0] o_out_right,
    output logic [tmrb_pkg::TIME_W-1:0]         o_late_frames,
    output logic [tmrb_pkg::SLOT_W-1:0]         o_slot_index
);
    import tmrb_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DATA  = 3'd3;
    localparam logic [2:0] S_MIX   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    t_index            r_clr_idx;
    t_index            r_play_idx;
    t_index            r_write_pos;
    logic [TIME_W-1:0] r_write_time;
    t_index            r_next_mix;

    logic [CMD_W-1:0]  r_cmd;
    t_frame            r_new;
    t_index            r_slot;
    logic [TIME_W-1:0] r_late;
    t_frame            r_entry;

    logic              r_out_valid;
    t_sample           r_out_left;
    t_sample           r_out_right;
    logic [TIME_W-1:0] r_out_late;
    logic [SLOT_W-1:0] r_out_slot;

    logic              w_accept;
    logic              w_out_free;
    logic              w_finish;
    logic [TIME_W-1:0] w_diff;
    t_index            w_slot;
    logic [TIME_W-1:0] w_late;
    t_frame            w_rd_data;
    t_store_wr         w_wr;
    logic              w_mix_start;
    logic              w_mix_done;
    t_frame            w_mixed;
    t_frame            w_in_frame;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_DONE) && w_out_free;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_in_frame.left  = i_left_sample;
    assign w_in_frame.right = i_right_sample;

    // Slot selection for the incoming transaction.
    always_comb begin
        w_diff = i_frame_time - r_write_time;
        w_late = '0;
        unique case (i_cmd)
            CMD_PLAY_TICK: begin
                w_slot = r_play_idx;
            end
            CMD_MIX_AT_TIME: begin
                if (w_diff[TIME_W-1]) begin
                    // Late frame: goes to the write position and reports the lag.
                    w_slot = r_write_pos;
                    w_late = r_write_time - i_frame_time;
                end else begin
                    w_slot = t_index'(r_write_pos + w_diff[IDX_W-1:0]);
                end
            end
            CMD_MIX_CONTINUE: begin
                w_slot = r_next_mix;
            end
            CMD_MIX_AT_WRITE: begin
                w_slot = r_write_pos;
            end
        endcase
    end

    // Transaction sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_idx == t_index'(STORE_FRAMES - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_READ;
            S_READ:  n_state = S_DATA;
            S_DATA:  n_state = (r_cmd == CMD_PLAY_TICK) ? S_DONE : S_MIX;
            S_MIX:   if (w_mix_done) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_mix_start = (r_state == S_DATA) && (r_cmd != CMD_PLAY_TICK);

    // Store writes: the clearing pass, then play clears and mix write-backs.
    always_comb begin
        w_wr.en   = 1'b0;
        w_wr.addr = r_slot;
        w_wr.data = '0;
        if (r_state == S_CLEAR) begin
            w_wr.en   = 1'b1;
            w_wr.addr = r_clr_idx;
        end else if (w_finish) begin
            w_wr.en   = 1'b1;
            w_wr.data = (r_cmd == CMD_PLAY_TICK) ? t_frame'('0) : w_mixed;
        end
    end

    // Control state and position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_play_idx   <= '0;
            r_write_pos  <= t_index'(LEAD_FRAMES);
            r_write_time <= TIME_W'(LEAD_FRAMES);
            r_next_mix   <= t_index'(LEAD_FRAMES);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= t_index'(r_clr_idx + 1'b1);
            end
            if (w_finish) begin
                if (r_cmd == CMD_PLAY_TICK) begin
                    r_play_idx   <= t_index'(r_play_idx + 1'b1);
                    r_write_pos  <= t_index'(r_write_pos + 1'b1);
                    r_write_time <= TIME_W'(r_write_time + 1'b1);
                end else begin
                    r_next_mix <= t_index'(r_slot + 1'b1);
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction payload and result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_new  <= w_in_frame;
            r_slot <= w_slot;
            r_late <= w_late;
        end
        if (r_state == S_DATA) begin
            r_entry <= w_rd_data;
        end
        if (w_finish) begin
            r_out_left  <= (r_cmd == CMD_PLAY_TICK) ? r_entry.left  : t_sample'(0);
            r_out_right <= (r_cmd == CMD_PLAY_TICK) ? r_entry.right : t_sample'(0);
            r_out_late  <= r_late;
            r_out_slot  <= SLOT_W'(r_slot);
        end
    end

    tmrb_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_slot),
        .o_rd_data (w_rd_data)
    );

    tmrb_mix_unit u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mix_start),
        .i_stored (w_rd_data),
        .i_new    (r_new),
        .o_done   (w_mix_done),
        .o_mixed  (w_mixed)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_left    = r_out_left;
    assign o_out_right   = r_out_right;
    assign o_late_frames = r_out_late;
    assign o_slot_index  = r_out_slot;

endmodule

// ===== sv/tmrb_checker.sv =====
`include "timestamped_mixing_ring_buffer_core_macros.svh"

module tmrb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_out_left,
    input logic signed [15:0] o_out_right,
    input logic [31:0]        o_late_frames
);

    // A result that is stalled stays offered.
    `TMRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // The block works on one transaction at a time.
    `TMRB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "transaction taken while busy")

    // Only mix results report lateness, and they carry silent samples.
    `TMRB_ASSERT_NOW(a_late_is_mix, i_clk, i_rst_n, o_out_valid && (o_late_frames != 32'd0), (o_out_left == 16'sd0) && (o_out_right == 16'sd0), "late count on a played frame")

    // Lateness never exceeds half the timestamp range.
    `TMRB_ASSERT_NOW(a_late_range, i_clk, i_rst_n, o_out_valid && o_late_frames[31], o_late_frames[30:0] == 31'd0, "late count out of range")

endmodule

bind timestamped_mixing_ring_buffer_core tmrb_checker u_tmrb_checker (.*);

// ===== sim/testbench.sv =====
module testbench;
    import tmrb_pkg::*;

    // One expected output transaction of the ring buffer.
    typedef struct packed {
        t_sample            left;
        t_sample            right;
        logic [TIME_W-1:0]  late;
        logic [SLOT_W-1:0]  slot;
    } ring_result_t;

    // Mirror of the frame ring: it keeps its own store, play position and mix
    // pointer, and queues the output each accepted transaction should produce.
    class stereo_ring_tracker;
        t_frame             frames [STORE_FRAMES];
        t_index             play_idx;
        t_index             next_mix_idx;
        logic [TIME_W-1:0]  play_stamp;
        ring_result_t       owed_results [$];
        int unsigned        mismatches;

        function new();
            foreach (frames[i]) frames[i] = '0;
            play_idx     = '0;
            play_stamp   = '0;
            next_mix_idx = t_index'(LEAD_FRAMES % STORE_FRAMES);
            mismatches   = 0;
        endfunction

        // Timestamp that belongs to the write position.
        function logic [TIME_W-1:0] write_stamp();
            return play_stamp + TIME_W'(LEAD_FRAMES);
        endfunction

        // Combine a held sample with a new one, as the mixer does per channel.
        function int mix_sample(int held, int incoming);
            longint u, v, m, r;
            if (held == 0) return incoming;
            if (incoming == 0) return held;
            u = 32767 + held / 2;
            v = 32767 + incoming / 2;
            if (u < 32767 && v < 32767)
                m = (u * v) / 32767;
            else
                m = 2 * (u + v) - (u * v) / 32767 - 65534;
            r = m - 32767;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return int'(r);
        endfunction

        // Apply one accepted input transaction and queue its expected output.
        function void note_input(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] ftime,
                                 t_sample new_left, t_sample new_right);
            ring_result_t      res;
            t_index            write_pos;
            t_index            slot;
            logic [TIME_W-1:0] diff;
            t_frame            held;
            res       = '0;
            write_pos = play_idx + t_index'(LEAD_FRAMES);
            if (cmd == CMD_PLAY_TICK) begin
                res.left  = frames[play_idx].left;
                res.right = frames[play_idx].right;
                res.slot  = play_idx;
                frames[play_idx] = '0;
                play_idx   = play_idx + 1'b1;
                play_stamp = play_stamp + 1'b1;
            end else begin
                case (cmd)
                    CMD_MIX_AT_TIME: begin
                        diff = ftime - write_stamp();
                        // A negative distance means the frame is late.
                        if (diff[TIME_W-1]) begin
                            res.late = 32'd0 - diff;
                            slot     = write_pos;
                        end else begin
                            slot = write_pos + diff[IDX_W-1:0];
                        end
                    end
                    CMD_MIX_CONTINUE: slot = next_mix_idx;
                    default:          slot = write_pos;
                endcase
                held = frames[slot];
                frames[slot].left  = t_sample'(mix_sample(int'(held.left), int'(new_left)));
                frames[slot].right = t_sample'(mix_sample(int'(held.right), int'(new_right)));
                next_mix_idx = slot + 1'b1;
                res.slot     = slot;
            end
            owed_results.push_back(res);
        endfunction

        // Compare one accepted output transaction with the oldest expectation.
        function void check_result(t_sample got_left, t_sample got_right,
                                   logic [TIME_W-1:0] got_late, logic [SLOT_W-1:0] got_slot);
            ring_result_t want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: left %0d right %0d late %0d slot %0d",
                             got_left, got_right, got_late, got_slot);
                return;
            end
            want = owed_results.pop_front();
            if (want.left !== got_left || want.right !== got_right ||
                want.late !== got_late || want.slot !== got_slot) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected left %0d right %0d late %0d slot %0d, %s",
                             want.left, want.right, want.late, want.slot,
                             $sformatf("got left %0d right %0d late %0d slot %0d",
                                       got_left, got_right, got_late, got_slot));
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd          = CMD_PLAY_TICK;
    logic [TIME_W-1:0]     i_frame_time   = '0;
    t_sample               i_left_sample  = '0;
    t_sample               i_right_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    t_sample               o_out_left;
    t_sample               o_out_right;
    logic [TIME_W-1:0]     o_late_frames;
    logic [SLOT_W-1:0]     o_slot_index;

    stereo_ring_tracker    tracker = new();
    bit                    gaps_on = 1'b0;
    int                    stall_left = 0;

    timestamped_mixing_ring_buffer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_frame_time   (i_frame_time),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_late_frames  (o_late_frames),
        .o_slot_index   (o_slot_index)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output backpressure comes in bursts while gaps are enabled.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Every output transaction is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_out_left, o_out_right, o_late_frames, o_slot_index);
    end

    // Offer one input transaction, hold it through stalls, and record it once accepted.
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] ftime,
                             input t_sample new_left, input t_sample new_right);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_frame_time   <= ftime;
        i_left_sample  <= new_left;
        i_right_sample <= new_right;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_input(cmd, ftime, new_left, new_right);
    endtask

    // Samples lean toward zero and the extremes, which steer the mixer's branches.
    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'sh7fff;
            2:       return 16'sh8000;
            3:       return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Timestamp for a mix at time, chosen relative to the current write timestamp.
    function automatic logic [TIME_W-1:0] pick_stamp();
        logic [TIME_W-1:0] base;
        base = tracker.write_stamp();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return base - $urandom_range(1, 1000);
            2, 3, 4: return base + $urandom_range(0, 15);
            // Wrap around the ring so the frame lands just ahead of the play index.
            5:       return base + (STORE_FRAMES - LEAD_FRAMES) + $urandom_range(0, 15);
            6:       return base + $urandom_range(0, STORE_FRAMES - 1);
            default: return base - $urandom;
        endcase
    endfunction

    // One random transaction; mixes near the write position dominate so slots get reused.
    task automatic push_random_item();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 2)
            push_item(CMD_PLAY_TICK, $urandom, pick_sample(), pick_sample());
        else if (pick <= 4)
            push_item(CMD_MIX_AT_WRITE, $urandom, pick_sample(), pick_sample());
        else if (pick <= 6)
            push_item(CMD_MIX_CONTINUE, $urandom, pick_sample(), pick_sample());
        else
            push_item(CMD_MIX_AT_TIME, pick_stamp(), pick_sample(), pick_sample());
    endtask

    // Main sequence: reset, directed cases, random traffic, then drain and report.
    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Continue before any mix uses the pointer's reset position.
        push_item(CMD_MIX_CONTINUE, 32'hffff_ffff, 16'sh7fff, 16'sh8000);
        // Repeated mixes into one slot cover zero, extreme and small samples.
        push_item(CMD_MIX_AT_WRITE, '0, '0, '0);
        push_item(CMD_MIX_AT_WRITE, '0, 16'sh7fff, 16'sh8000);
        push_item(CMD_MIX_AT_WRITE, '0, 16'sh7fff, 16'sh8000);
        push_item(CMD_MIX_AT_WRITE, '0, -16'sd1, 16'sd1);
        push_item(CMD_MIX_AT_WRITE, '0, 16'sh8000, 16'sh7fff);
        push_item(CMD_MIX_AT_WRITE, '0, 16'sh8000, 16'sh8000);
        // Timestamps exactly on time, just late, most negative and farthest ahead.
        push_item(CMD_MIX_AT_TIME, tracker.write_stamp(), 16'sd1000, -16'sd1000);
        push_item(CMD_MIX_AT_TIME, tracker.write_stamp() - 1, 16'sd2000, 16'sd3);
        push_item(CMD_MIX_AT_TIME, tracker.write_stamp() + 32'h8000_0000, 16'sd5, 16'sd7);
        push_item(CMD_MIX_AT_TIME, tracker.write_stamp() + 32'h7fff_ffff, 16'sh7fff, 16'sh7fff);
        push_item(CMD_MIX_AT_TIME, 32'hffff_ffff, -16'sd12345, 16'sd12345);
        push_item(CMD_MIX_AT_TIME, 32'h0000_0000, 16'sd4321, -16'sd4321);
        // A far future frame that wraps onto the play index, then continues past it.
        push_item(CMD_MIX_AT_TIME, tracker.write_stamp() + (STORE_FRAMES - LEAD_FRAMES),
                  16'sh7fff, 16'sh8000);
        push_item(CMD_MIX_CONTINUE, '0, -16'sd20000, 16'sd20000);
        push_item(CMD_MIX_CONTINUE, '0, 16'sd300, -16'sd300);
        // Play ticks read those frames back and clear them.
        repeat (3) push_item(CMD_PLAY_TICK, $urandom, pick_sample(), pick_sample());
        // Continue past the played frames, then mix a frame into a slot that was just played.
        push_item(CMD_MIX_CONTINUE, '0, 16'sd1, -16'sd1);
        push_item(CMD_MIX_AT_TIME, tracker.write_stamp() + (STORE_FRAMES - LEAD_FRAMES) - 1,
                  16'sd99, -16'sd99);
        push_item(CMD_PLAY_TICK, '0, '0, '0);

        // Random traffic in stretches with and without gaps; the tail runs without them.
        for (int n = 0; n < 750; n++) begin
            if (n % 60 == 0)
                gaps_on = (n < 650) && ($urandom_range(0, 3) != 0);
            if (n == 650)
                gaps_on = 1'b0;
            push_random_item();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain everything still owed, then let the block run on before the report.
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.owed_results.size() == 0)
            $display("timestamped_mixing_ring_buffer_core verification clean");
        else
            $display("timestamped_mixing_ring_buffer_core verification failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("timestamped_mixing_ring_buffer_core verification failed");
        $finish;
    end

endmodule
